/* hdl/drmpg_pkg.sv */
// Shared widths, constants, register indexes and types for the proximity gate.
`default_nettype none

package drmpg_pkg;

  localparam int unsigned ECHO_W     = 16;
  localparam int unsigned DIST_W     = 11;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned UPPER_W    = DIST_W + 1;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SOUND_NUM  = 343;
  localparam int unsigned SOUND_DEN  = 20000;
  // floor(x * 343 / 20000) equals (x * RECIP_MUL) >> RECIP_SHIFT for every 16-bit x
  localparam int unsigned RECIP_MUL   = 36829345;
  localparam int unsigned RECIP_SHIFT = 31;
  localparam int unsigned PROD_W      = RECIP_SHIFT + DIST_W;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MARGIN = CFG_IDX_W'(1);

  localparam logic [DIST_W-1:0]   THRESHOLD_RESET = DIST_W'(20);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET    = MARGIN_W'(5);

  typedef logic [ECHO_W-1:0] echo_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

/* hdl/drmpg_in_if.sv */
// Input channel: one pair of echo widths per word.
`default_nettype none

interface drmpg_in_if
  import drmpg_pkg::*;
();
  logic  valid;
  logic  ready;
  echo_t echo_us_a;
  echo_t echo_us_b;

  modport source (output valid, output echo_us_a, output echo_us_b, input ready);
  modport sink   (input valid, input echo_us_a, input echo_us_b, output ready);
endinterface

`default_nettype wire

/* hdl/drmpg_out_if.sv */
// Output channel: gate state and both medians per word.
`default_nettype none

interface drmpg_out_if
  import drmpg_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  path_clear;
  dist_t median_cm_a;
  dist_t median_cm_b;

  modport source (output valid, output path_clear, output median_cm_a,
                  output median_cm_b, input ready);
  modport sink   (input valid, input path_clear, input median_cm_a,
                  input median_cm_b, output ready);
endinterface

`default_nettype wire

/* hdl/drmpg_cfg_if.sv */
// Configuration write channel: register index and data per word.
`default_nettype none

interface drmpg_cfg_if
  import drmpg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/dual_range_median_proximity_gate.sv */
// Top level: echo-to-distance scaling, median windows and hysteresis gate.
//
//  channel  | dir | words carried
//  ---------+-----+-------------------------------------------
//  in_i     | in  | echo_us_a, echo_us_b
//  out_o    | out | path_clear, median_cm_a, median_cm_b
//  cfg_i    | in  | index, data (near_threshold, release_margin)
//
// Each word passes through one reciprocal multiply (S_MUL), one ring write
// (S_WRITE), then one candidate per cycle through the rank-count unit (S_SCAN),
// and the gate decision (S_DONE), which waits for the output register; in_i is
// ready again once the state returns to S_IDLE.
// in_i is ready only while idle; a finished result holds in the output
// register, and the next word proceeds until it needs that register.
// Reset clears rings, ring position, gate state and registers to defaults.
`default_nettype none

module dual_range_median_proximity_gate
  import drmpg_pkg::*;
#(
  parameter int unsigned WINDOW = 13
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  drmpg_in_if.sink     in_i,
  drmpg_out_if.source  out_o,
  drmpg_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [DIST_W-1:0]   thr_q;
  logic [MARGIN_W-1:0] margin_q;

  echo_t echo_a_q, echo_b_q;
  prod_t prod_a_q, prod_b_q;

  dist_t win_a_q [WINDOW];
  dist_t win_b_q [WINDOW];
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] cand_q;

  dist_t cand_a, cand_b;
  logic [CNT_W-1:0] lt_a, le_a, lt_b, le_b;
  logic hit_a, hit_b;
  dist_t med_a_q, med_b_q;

  logic gate_q, gate_d;
  logic [UPPER_W-1:0] upper;
  logic out_valid_q, out_path_q;
  dist_t out_med_a_q, out_med_b_q;
  logic in_fire, out_fire, out_load;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_valid_q & out_o.ready;
  assign out_load = (state_q == S_DONE) & (~out_valid_q | out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.path_clear  = out_path_q;
  assign out_o.median_cm_a = out_med_a_q;
  assign out_o.median_cm_b = out_med_b_q;

  // rank the current candidate against every ring entry
  always_comb begin
    cand_a = win_a_q[cand_q];
    cand_b = win_b_q[cand_q];
    lt_a = '0;
    le_a = '0;
    lt_b = '0;
    le_b = '0;
    for (int j = 0; j < WINDOW; j++) begin
      lt_a = lt_a + CNT_W'(win_a_q[j] <  cand_a);
      le_a = le_a + CNT_W'(win_a_q[j] <= cand_a);
      lt_b = lt_b + CNT_W'(win_b_q[j] <  cand_b);
      le_b = le_b + CNT_W'(win_b_q[j] <= cand_b);
    end
    hit_a = (lt_a <= MID_RANK) && (le_a > MID_RANK);
    hit_b = (lt_b <= MID_RANK) && (le_b > MID_RANK);
  end

  always_comb begin
    upper  = UPPER_W'(thr_q) + UPPER_W'(margin_q);
    gate_d = gate_q;
    priority if ((med_a_q < thr_q) || (med_b_q < thr_q)) begin
      gate_d = 1'b0;
    end else if ((UPPER_W'(med_a_q) > upper) && (UPPER_W'(med_b_q) > upper)) begin
      gate_d = 1'b1;
    end else begin
      gate_d = gate_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MUL;
      S_MUL:   state_d = S_WRITE;
      S_WRITE: state_d = S_SCAN;
      S_SCAN:  if (cand_q == LAST_IDX) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THRESHOLD_RESET;
      margin_q    <= MARGIN_RESET;
      slot_q      <= '0;
      gate_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        win_a_q[i] <= '0;
        win_b_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == REG_NEAR_THRESHOLD) begin
          thr_q <= cfg_i.data[DIST_W-1:0];
        end else if (cfg_i.index == REG_RELEASE_MARGIN) begin
          margin_q <= cfg_i.data[MARGIN_W-1:0];
        end
      end
      if (state_q == S_WRITE) begin
        win_a_q[slot_q] <= prod_a_q[RECIP_SHIFT +: DIST_W];
        win_b_q[slot_q] <= prod_b_q[RECIP_SHIFT +: DIST_W];
        slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
      end
      if (out_load) begin
        gate_q <= gate_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      echo_a_q <= in_i.echo_us_a;
      echo_b_q <= in_i.echo_us_b;
    end
    unique case (state_q)
      S_MUL: begin
        prod_a_q <= prod_t'(echo_a_q) * prod_t'(RECIP_MUL);
        prod_b_q <= prod_t'(echo_b_q) * prod_t'(RECIP_MUL);
      end
      S_WRITE: begin
        cand_q <= '0;
      end
      S_SCAN: begin
        if (hit_a) med_a_q <= cand_a;
        if (hit_b) med_b_q <= cand_b;
        cand_q <= cand_q + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_path_q  <= gate_d;
      out_med_a_q <= med_a_q;
      out_med_b_q <= med_b_q;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_dual_range_median_proximity_gate.sv */
// Self-checking testbench for the dual-sensor median proximity gate.
`timescale 1ns / 100ps

module tb_dual_range_median_proximity_gate;
  import drmpg_pkg::*;

  localparam int unsigned WINDOW_LEN   = 13;
  localparam int unsigned MID_RANK     = WINDOW_LEN / 2;
  localparam int unsigned DIST_TOP     = (1 << DIST_W) - 1;
  localparam int unsigned CM_TOP       = (((1 << ECHO_W) - 1) * SOUND_NUM) / SOUND_DEN;
  localparam int unsigned DRAIN_CYCLES = WINDOW_LEN + 15 + 8;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 175;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_RELEASE_MARGIN + 1'b1;

  typedef enum int unsigned {BAND_BELOW, BAND_HYST, BAND_ABOVE, BAND_WILD} band_e;

  typedef struct packed {
    logic  clear;
    dist_t cm_a;
    dist_t cm_b;
  } gate_word_t;

  class gate_tracker;
    dist_t                 thr;
    logic [MARGIN_W-1:0]   margin;
    dist_t                 ring_a[WINDOW_LEN];
    dist_t                 ring_b[WINDOW_LEN];
    int unsigned           slot;
    logic                  gate;
    gate_word_t            gate_due_q[$];
    int unsigned           checked;
    int unsigned           errors;

    function new();
      thr     = THRESHOLD_RESET;
      margin  = MARGIN_RESET;
      slot    = 0;
      gate    = 1'b0;
      checked = 0;
      errors  = 0;
      foreach (ring_a[i]) begin
        ring_a[i] = '0;
        ring_b[i] = '0;
      end
    endfunction

    function dist_t echo_to_cm(input echo_t us);
      int unsigned cm;
      cm = (int'(us) * SOUND_NUM) / SOUND_DEN;
      if (cm > DIST_TOP) cm = DIST_TOP;
      return dist_t'(cm);
    endfunction

    function dist_t ring_median(input dist_t ring[WINDOW_LEN]);
      int unsigned below, same;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        below = 0;
        same  = 0;
        for (int j = 0; j < WINDOW_LEN; j++) begin
          if (ring[j] < ring[i]) below++;
          else if (ring[j] == ring[i]) same++;
        end
        if (below <= MID_RANK && MID_RANK < below + same) return ring[i];
      end
      return '0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_NEAR_THRESHOLD) thr = data[DIST_W-1:0];
      else if (idx == REG_RELEASE_MARGIN) margin = data[MARGIN_W-1:0];
    endfunction

    function void note_echo(input echo_t us_a, input echo_t us_b);
      gate_word_t          w;
      logic [UPPER_W-1:0]  upper;
      ring_a[slot] = echo_to_cm(us_a);
      ring_b[slot] = echo_to_cm(us_b);
      slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
      w.cm_a = ring_median(ring_a);
      w.cm_b = ring_median(ring_b);
      upper  = UPPER_W'(thr) + UPPER_W'(margin);
      if (w.cm_a < thr || w.cm_b < thr) gate = 1'b0;
      else if (UPPER_W'(w.cm_a) > upper && UPPER_W'(w.cm_b) > upper) gate = 1'b1;
      w.clear = gate;
      gate_due_q.push_back(w);
    endfunction

    function void check_gate(input logic clear, input dist_t cm_a, input dist_t cm_b);
      gate_word_t w;
      if (gate_due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word clear=%0b a=%0d b=%0d", $realtime, clear, cm_a, cm_b);
        return;
      end
      w = gate_due_q.pop_front();
      checked++;
      if (clear !== w.clear || cm_a !== w.cm_a || cm_b !== w.cm_b) begin
        errors++;
        if (errors <= 10)
          $display("%0t: word %0d mismatch: clear %0b/%0b a %0d/%0d b %0d/%0d (exp/got)",
                   $realtime, checked, w.clear, clear, w.cm_a, cm_a, w.cm_b, cm_b);
      end
    endfunction

    function int unsigned pending();
      return gate_due_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  drmpg_in_if  echo_if ();
  drmpg_out_if gate_if ();
  drmpg_cfg_if cfg_if ();

  dual_range_median_proximity_gate #(
    .WINDOW (WINDOW_LEN)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (echo_if),
    .out_o  (gate_if),
    .cfg_i  (cfg_if)
  );

  gate_tracker tracker = new();
  bit          no_idle = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               tracker.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      gate_if.ready <= 1'b0;
    end else begin
      if (gate_if.valid && gate_if.ready) begin
        tracker.check_gate(gate_if.path_clear, gate_if.median_cm_a, gate_if.median_cm_b);
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait != 0) begin
        gate_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        gate_if.ready <= 1'b1;
      end
    end
  end

  function automatic echo_t width_for_cm(input int unsigned cm);
    return echo_t'((cm * SOUND_DEN + SOUND_NUM - 1) / SOUND_NUM);
  endfunction

  function automatic echo_t echo_in_band(input band_e band);
    int          lo, hi;
    int unsigned cm, w;
    case (band)
      BAND_BELOW: begin
        lo = int'(tracker.thr) - 12;
        hi = int'(tracker.thr) - 1;
      end
      BAND_HYST: begin
        lo = int'(tracker.thr);
        hi = int'(tracker.thr) + int'(tracker.margin);
      end
      BAND_ABOVE: begin
        lo = int'(tracker.thr) + int'(tracker.margin) + 1;
        hi = lo + 11;
      end
      default: return echo_t'($urandom);
    endcase
    if (hi > int'(CM_TOP)) hi = CM_TOP;
    if (hi < 0) hi = 0;
    if (lo < 0) lo = 0;
    if (lo > hi) lo = hi;
    cm = $urandom_range(hi, lo);
    w  = int'(width_for_cm(cm)) + $urandom_range(0, 57);
    if (w > (1 << ECHO_W) - 1) w = (1 << ECHO_W) - 1;
    return echo_t'(w);
  endfunction

  task automatic send_echo(input echo_t us_a, input echo_t us_b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      echo_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    echo_if.valid     <= 1'b1;
    echo_if.echo_us_a <= us_a;
    echo_if.echo_us_b <= us_b;
    do @(posedge clk_i); while (!echo_if.ready);
    tracker.note_echo(us_a, us_b);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    echo_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned thr, input int unsigned margin);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_UNMAPPED_FIRST)), junk);
    junk = $urandom;
    write_reg(REG_NEAR_THRESHOLD, (junk & ~CFG_DATA_W'(DIST_TOP)) | CFG_DATA_W'(thr));
    junk = $urandom;
    write_reg(REG_RELEASE_MARGIN,
              (junk & ~CFG_DATA_W'((1 << MARGIN_W) - 1)) | CFG_DATA_W'(margin));
  endtask

  int unsigned phase_thr[PHASES]    = '{20, 0, 2047, 1123, 0, 300, 0, 20};
  int unsigned phase_margin[PHASES] = '{5, 0, 255, 0, 255, 17, 0, 5};

  initial begin
    int unsigned run_left;
    band_e       band_a, band_b;
    int unsigned settings;

    rst_ni            = 1'b0;
    echo_if.valid     = 1'b0;
    echo_if.echo_us_a = '0;
    echo_if.echo_us_b = '0;
    gate_if.ready     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    settings          = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_echo('0, '0);
    send_echo('1, '1);
    send_echo(16'hAAAA, 16'h5555);
    send_echo(16'h5555, 16'hAAAA);
    repeat (6) send_echo(width_for_cm(30), '1);
    repeat (5) send_echo(width_for_cm(THRESHOLD_RESET + MARGIN_RESET), width_for_cm(22));
    repeat (5) send_echo(width_for_cm(THRESHOLD_RESET), width_for_cm(THRESHOLD_RESET));
    repeat (4) send_echo(width_for_cm(5), '1);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase != 0) begin
        if (phase == 6) apply_setting($urandom_range(CM_TOP, 0), $urandom_range(255, 0));
        else apply_setting(phase_thr[phase], phase_margin[phase]);
        settings++;
      end
      run_left = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(24, 6);
          band_a   = band_e'($urandom_range(BAND_WILD, BAND_BELOW));
          band_b   = band_e'($urandom_range(BAND_WILD, BAND_BELOW));
        end
        run_left--;
        if ($urandom_range(39, 0) == 0) no_idle = !no_idle;
        if ($urandom_range(6, 0) == 0) send_echo(echo_t'($urandom), echo_t'($urandom));
        else send_echo(echo_in_band(band_a), echo_in_band(band_b));
      end
    end

    drain_results();
    $display("Checked %0d gate words from %0d echo words over %0d register settings.",
             tracker.checked, words_sent, settings);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never returned", tracker.errors, tracker.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
